// ===== rtl/core/pisc_pkg.sv =====
// ----------------------------------------------------------------------------
// pisc_pkg
// Shared widths, register indexes, override codes, reset values, payload
// types and the symmetric clamp used by the PI speed controller.
// ----------------------------------------------------------------------------
package pisc_pkg;

  localparam int CountW  = 16;
  localparam int TargetW = 16;
  localparam int OvrW    = 2;
  localparam int GainW   = 8;
  localparam int LimitW  = 11;
  localparam int DriveW  = 12;
  localparam int SpeedW  = 16;
  localparam int IdxW    = 3;
  localparam int ErrW    = 18;
  localparam int ProdW   = 26;
  localparam int SumW    = 27;

  localparam logic [IdxW-1:0] REG_PROP_GAIN = 3'd0;
  localparam logic [IdxW-1:0] REG_INT_GAIN  = 3'd1;
  localparam logic [IdxW-1:0] REG_INT_LIMIT = 3'd2;
  localparam logic [IdxW-1:0] REG_OUT_LIMIT = 3'd3;
  localparam logic [IdxW-1:0] REG_DEADBAND  = 3'd4;

  localparam logic [OvrW-1:0] OVR_NORMAL = 2'd0;
  localparam logic [OvrW-1:0] OVR_COAST  = 2'd1;
  localparam logic [OvrW-1:0] OVR_BRAKE  = 2'd2;

  localparam logic [GainW-1:0]  PROP_GAIN_RST = 8'd15;
  localparam logic [GainW-1:0]  INT_GAIN_RST  = 8'd2;
  localparam logic [LimitW-1:0] INT_LIMIT_RST = 11'd100;
  localparam logic [LimitW-1:0] OUT_LIMIT_RST = 11'd980;
  localparam logic [LimitW-1:0] DEADBAND_RST  = 11'd70;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  int_gain;
    logic [LimitW-1:0] int_limit;
    logic [LimitW-1:0] out_limit;
    logic [LimitW-1:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0]         encoder_count;
    logic signed [TargetW-1:0] speed_target;
    logic [OvrW-1:0]           drive_override;
  } item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive_level;
    logic                     pin_a;
    logic                     pin_b;
    logic signed [SpeedW-1:0] measured_speed;
  } result_t;

  typedef struct packed {
    logic valid;
    logic take;
  } xfer_t;

  function automatic logic signed [DriveW-1:0] clamp_sym(
    input logic signed [SumW-1:0] v,
    input logic [LimitW-1:0]      lim
  );
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [SumW-1:0] r;
    hi = SumW'($signed({1'b0, lim}));
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[DriveW-1:0];
  endfunction

endpackage

// ===== rtl/core/encoder_pi_speed_controller.sv =====
// ----------------------------------------------------------------------------
// encoder_pi_speed_controller
// PI speed loop for one DC motor: encoder count in, drive level and
// H-bridge pin levels out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per control tick with
//   the raw encoder count, the signed speed target and the drive override.
//   Result channel (out_valid/out_ready): one transaction per input, in
//   order, with drive level, bridge pins and measured speed.
//   Configuration (cfg_we/cfg_index/cfg_data): gains, limits and deadband,
//   written through an indexed port; write only while no transaction is in flight.
//   Path: the accepted input waits in the input register, the result is
//   computed from it combinationally and captured in the result register.
//   Throughput: one transaction per cycle while out_ready is high. The
//   integrator and previous count update in the same cycle the result loads.
//   Stall: while the receiver holds out_ready low the result register holds,
//   an empty input register takes one more transaction, then in_ready drops.
//   Reset: both registers empty, previous count and integrator zero, the
//   configuration registers return to their default values.
// ----------------------------------------------------------------------------
module encoder_pi_speed_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pisc_pkg::IdxW-1:0]           cfg_index,
  input  logic [pisc_pkg::LimitW-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pisc_pkg::CountW-1:0]         in_encoder_count,
  input  logic signed [pisc_pkg::TargetW-1:0] in_speed_target,
  input  logic [pisc_pkg::OvrW-1:0]           in_drive_override,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pisc_pkg::DriveW-1:0]  out_drive_level,
  output logic                                out_pin_a,
  output logic                                out_pin_b,
  output logic signed [pisc_pkg::SpeedW-1:0]  out_measured_speed
);

  pisc_pkg::cfg_t    cfg;
  pisc_pkg::item_t   in_item;
  pisc_pkg::item_t   item;
  pisc_pkg::result_t res;
  pisc_pkg::result_t out_res;
  pisc_pkg::xfer_t   xfer;
  logic              stage_valid;
  logic              take;

  assign in_item.encoder_count  = in_encoder_count;
  assign in_item.speed_target   = in_speed_target;
  assign in_item.drive_override = in_drive_override;

  assign xfer.valid = stage_valid;
  assign xfer.take  = take;

  pisc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pisc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .valid    (stage_valid),
    .item     (item)
  );

  pisc_law u_law (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item),
    .xfer  (xfer),
    .res   (res)
  );

  pisc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (stage_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_drive_level    = out_res.drive_level;
  assign out_pin_a          = out_res.pin_a;
  assign out_pin_b          = out_res.pin_b;
  assign out_measured_speed = out_res.measured_speed;

endmodule

// ===== rtl/core/pisc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pisc_cfg_regs
// Gain, limit and deadband registers behind a plain indexed write port.
// ----------------------------------------------------------------------------
module pisc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pisc_pkg::IdxW-1:0]    cfg_index,
  input  logic [pisc_pkg::LimitW-1:0]  cfg_data,
  output pisc_pkg::cfg_t               cfg
);

  pisc_pkg::cfg_t cfg_r;
  pisc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pisc_pkg::REG_PROP_GAIN: cfg_nxt.prop_gain = cfg_data[pisc_pkg::GainW-1:0];
        pisc_pkg::REG_INT_GAIN:  cfg_nxt.int_gain  = cfg_data[pisc_pkg::GainW-1:0];
        pisc_pkg::REG_INT_LIMIT: cfg_nxt.int_limit = cfg_data;
        pisc_pkg::REG_OUT_LIMIT: cfg_nxt.out_limit = cfg_data;
        pisc_pkg::REG_DEADBAND:  cfg_nxt.deadband  = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain <= pisc_pkg::PROP_GAIN_RST;
      cfg_r.int_gain  <= pisc_pkg::INT_GAIN_RST;
      cfg_r.int_limit <= pisc_pkg::INT_LIMIT_RST;
      cfg_r.out_limit <= pisc_pkg::OUT_LIMIT_RST;
      cfg_r.deadband  <= pisc_pkg::DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/pisc_in_stage.sv =====
// ----------------------------------------------------------------------------
// pisc_in_stage
// Input register: captures one transaction and holds it until the result
// stage takes it.
// ----------------------------------------------------------------------------
module pisc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pisc_pkg::item_t in_item,
  input  logic            take,
  output logic            valid,
  output pisc_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  logic            load;
  pisc_pkg::item_t item_r;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ===== rtl/core/pisc_law.sv =====
// ----------------------------------------------------------------------------
// pisc_law
// Speed measurement, PI law with clamped integrator, drive clamp and bridge
// pin decode. Holds the previous count and the integrator.
// ----------------------------------------------------------------------------
module pisc_law (
  input  logic              clk,
  input  logic              rst_n,
  input  pisc_pkg::cfg_t    cfg,
  input  pisc_pkg::item_t   item,
  input  pisc_pkg::xfer_t   xfer,
  output pisc_pkg::result_t res
);

  logic [pisc_pkg::CountW-1:0]         prev_count_r;
  logic signed [pisc_pkg::DriveW-1:0]  integ_r;
  logic signed [pisc_pkg::DriveW-1:0]  integ_nxt;
  logic                                fire;

  logic [pisc_pkg::CountW-1:0]         diff;
  logic signed [pisc_pkg::SpeedW-1:0]  speed;
  logic signed [pisc_pkg::ErrW-1:0]    err;
  logic signed [pisc_pkg::ProdW-1:0]   int_prod;
  logic signed [pisc_pkg::ProdW-1:0]   prop_prod;
  logic signed [pisc_pkg::SumW-1:0]    int_sum;
  logic signed [pisc_pkg::SumW-1:0]    drive_sum;
  logic signed [pisc_pkg::DriveW-1:0]  drive;
  logic signed [pisc_pkg::DriveW-1:0]  db_pos;
  logic signed [pisc_pkg::DriveW-1:0]  db_neg;
  logic                                pa;
  logic                                pb;

  assign fire = xfer.valid && xfer.take;

  always_comb begin
    diff      = item.encoder_count - prev_count_r;
    speed     = $signed(diff);
    err       = pisc_pkg::ErrW'(item.speed_target) - pisc_pkg::ErrW'(speed);
    int_prod  = pisc_pkg::ProdW'($signed({1'b0, cfg.int_gain})) * pisc_pkg::ProdW'(err);
    prop_prod = pisc_pkg::ProdW'($signed({1'b0, cfg.prop_gain})) * pisc_pkg::ProdW'(err);
    int_sum   = pisc_pkg::SumW'(integ_r) + pisc_pkg::SumW'(int_prod);
    integ_nxt = pisc_pkg::clamp_sym(int_sum, cfg.int_limit);
    drive_sum = pisc_pkg::SumW'(prop_prod) + pisc_pkg::SumW'(integ_nxt);
    drive     = pisc_pkg::clamp_sym(drive_sum, cfg.out_limit);
    db_pos    = $signed({1'b0, cfg.deadband});
    db_neg    = -db_pos;
  end

  always_comb begin
    pa = 1'b0;
    pb = 1'b0;
    unique case (item.drive_override)
      pisc_pkg::OVR_COAST: begin
        pa = 1'b0;
        pb = 1'b0;
      end
      pisc_pkg::OVR_BRAKE: begin
        pa = 1'b1;
        pb = 1'b1;
      end
      default: begin
        if (drive > db_pos) begin
          pb = 1'b1;
        end else if (drive < db_neg) begin
          pa = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      integ_r      <= '0;
    end else if (fire) begin
      prev_count_r <= item.encoder_count;
      integ_r      <= integ_nxt;
    end
  end

  assign res.drive_level    = drive;
  assign res.pin_a          = pa;
  assign res.pin_b          = pb;
  assign res.measured_speed = speed;

endmodule

// ===== rtl/core/pisc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pisc_out_stage
// Result register: holds a finished transaction until the receiver takes it
// and frees the input register whenever it can advance.
// ----------------------------------------------------------------------------
module pisc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid,
  input  pisc_pkg::result_t res,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output pisc_pkg::result_t out_res
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  pisc_pkg::result_t out_res_r;

  assign take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/core/pisc_checker.sv =====
// ----------------------------------------------------------------------------
// pisc_checker
// Port-level checks for the PI speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module pisc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [pisc_pkg::DriveW-1:0]  out_drive_level,
  input logic                                out_pin_a,
  input logic                                out_pin_b,
  input logic signed [pisc_pkg::SpeedW-1:0]  out_measured_speed
);

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while receiver is ready");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_level)
      && $stable(out_pin_a) && $stable(out_pin_b) && $stable(out_measured_speed))
    else $error("stalled result changed");

  a_pin_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pin_a && !out_pin_b && out_drive_level >= 0)
      && !(!out_pin_a && out_pin_b && out_drive_level <= 0))
    else $error("bridge direction disagrees with drive sign");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive_level != -(pisc_pkg::DriveW'(2048)))
    else $error("drive level outside symmetric range");

endmodule

bind encoder_pi_speed_controller pisc_checker u_pisc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_drive_level    (out_drive_level),
  .out_pin_a          (out_pin_a),
  .out_pin_b          (out_pin_b),
  .out_measured_speed (out_measured_speed)
);
